@@ design/csw_pkg.sv @@
// Shared types and constants for the counting semaphore with wait list.
`default_nettype none
package csw_pkg;

    localparam int WAIT_DEPTH = 32;
    localparam int ADDR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int ID_W = 22;
    localparam int UNITS_W = 16;

    localparam logic [UNITS_W-1:0] UNITS_MAX = '1;
    localparam logic [CNT_W-1:0] LIST_FULL = CNT_W'(WAIT_DEPTH);

    localparam logic STATUS_GRANTED = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]           requester_id;
        logic signed [UNITS_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic            status;
        logic            last;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [UNITS_W-1:0] need;
    } waiter_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic rel_start;
        logic acq_grant;
        logic acq_queue;
        logic acq_drop;
        logic scan_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_release;
        logic acq_fits;
        logic list_full;
        logic count_zero;
        logic out_free;
        logic scan_grant;
        logic scan_last;
    } stat_t;

endpackage
`default_nettype wire

@@ design/counting_semaphore_waitlist.sv @@
// Counting semaphore with an ordered wait list of up to 32 waiters.
//
// Requests enter on req (requester_id, signed amount) with req_valid/req_ready.
// A positive amount releases units (count saturates at 65535); zero or a
// negative amount acquires -amount units, is granted at once when covered,
// otherwise waits in the list, or is dropped (status 1) when the list is full.
// Results leave on rsp (granted_id, status, last) with rsp_valid/rsp_ready.
// One request is handled at a time; req_ready is high only while idle.
// An acquire is decided in ST_DECIDE, then its result enters the output register.
// A release scans one stored waiter per cycle unless a grant waits for the output,
// paced by the single read port of the wait list memory; the releaser's grant comes
// first, the granted waiters follow in list order, the last result has last=1.
// A queued acquire produces no result.
// Results pass through an output register; when the receiver stalls, work
// halts on the next result that needs the output until it is taken.
// Reset clears the unit count, the waiter count and the output valid flag.
`default_nettype none
module counting_semaphore_waitlist (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire csw_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output csw_pkg::rsp_t      rsp
);

    csw_pkg::cmd_t  cmd;
    csw_pkg::stat_t stat;

    csw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    csw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
`default_nettype wire

@@ design/csw_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module csw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ design/csw_ctrl.sv @@
// Controller state machine sequencing acquires, releases and the list scan.
`default_nettype none
module csw_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire csw_pkg::stat_t stat,
    output csw_pkg::cmd_t       cmd
);

    csw_pkg::state_t state_reg;
    csw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            csw_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = csw_pkg::ST_DECIDE;
                end
            end
            csw_pkg::ST_DECIDE:
            begin
                if (stat.is_release)
                begin
                    cmd.rel_start = 1'b1;
                    state_next = stat.count_zero ? csw_pkg::ST_FINISH : csw_pkg::ST_SCAN;
                end
                else if (stat.acq_fits)
                begin
                    if (stat.out_free)
                    begin
                        cmd.acq_grant = 1'b1;
                        state_next = csw_pkg::ST_IDLE;
                    end
                end
                else if (!stat.list_full)
                begin
                    cmd.acq_queue = 1'b1;
                    state_next = csw_pkg::ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.acq_drop = 1'b1;
                    state_next = csw_pkg::ST_IDLE;
                end
            end
            csw_pkg::ST_SCAN:
            begin
                // A waiter that is kept never needs the output; a granted one does.
                if (!stat.scan_grant || stat.out_free)
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = csw_pkg::ST_FINISH;
                    end
                end
            end
            csw_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = csw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = csw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/csw_datapath.sv @@
// Datapath: unit count, wait list memory, scan pointers and output register.
`default_nettype none
module csw_datapath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire csw_pkg::req_t  req,
    output csw_pkg::rsp_t       rsp,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    input  wire csw_pkg::cmd_t  cmd,
    output csw_pkg::stat_t      stat
);

    localparam int WAITER_W = $bits(csw_pkg::waiter_t);

    csw_pkg::req_t                   req_reg;
    logic [csw_pkg::UNITS_W-1:0]     avail_reg;
    logic [csw_pkg::UNITS_W-1:0]     avail_next;
    logic [csw_pkg::CNT_W-1:0]       count_reg;
    logic [csw_pkg::CNT_W-1:0]       count_next;
    logic [csw_pkg::CNT_W-1:0]       idx_reg;
    logic [csw_pkg::CNT_W-1:0]       kept_reg;
    logic [csw_pkg::ID_W-1:0]        pend_reg;
    logic                            out_valid_reg;
    csw_pkg::rsp_t                   out_reg;

    logic [csw_pkg::UNITS_W-1:0]     acq_need;
    logic [csw_pkg::UNITS_W:0]       rel_sum;
    logic [csw_pkg::CNT_W-1:0]       idx_inc;
    logic                            push;
    csw_pkg::rsp_t                   push_data;

    logic                            wr_en;
    logic [csw_pkg::ADDR_W-1:0]      wr_addr;
    csw_pkg::waiter_t                wr_waiter;
    logic                            rd_en;
    logic [csw_pkg::ADDR_W-1:0]      rd_addr;
    logic [WAITER_W-1:0]             rd_bits;
    csw_pkg::waiter_t                rd_waiter;

    csw_ram #(
        .WIDTH(WAITER_W),
        .DEPTH(csw_pkg::WAIT_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_waiter),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_waiter = csw_pkg::waiter_t'(rd_bits);

    // Acquire need is the negated amount; zero stays zero and -32768 maps to 32768.
    assign acq_need = ~req_reg.amount + csw_pkg::UNITS_W'(1);
    assign rel_sum = {1'b0, avail_reg} + {1'b0, req_reg.amount};
    assign idx_inc = idx_reg + csw_pkg::CNT_W'(1);

    always_comb
    begin
        stat.is_release = !req_reg.amount[csw_pkg::UNITS_W-1] && (req_reg.amount != '0);
        stat.acq_fits   = avail_reg >= acq_need;
        stat.list_full  = count_reg == csw_pkg::LIST_FULL;
        stat.count_zero = count_reg == '0;
        stat.out_free   = !out_valid_reg || rsp_ready;
        stat.scan_grant = avail_reg >= rd_waiter.need;
        stat.scan_last  = idx_inc == count_reg;
    end

    // Waiter reads run one ahead; the compaction write at kept never passes the read point.
    always_comb
    begin
        rd_en = (cmd.rel_start && count_reg != '0) || (cmd.scan_step && !stat.scan_last);
        rd_addr = cmd.rel_start ? '0 : idx_inc[csw_pkg::ADDR_W-1:0];
        wr_en = 1'b0;
        wr_addr = kept_reg[csw_pkg::ADDR_W-1:0];
        wr_waiter = rd_waiter;
        if (cmd.acq_queue)
        begin
            wr_en = 1'b1;
            wr_addr = count_reg[csw_pkg::ADDR_W-1:0];
            wr_waiter.id = req_reg.requester_id;
            wr_waiter.need = acq_need;
        end
        else if (cmd.scan_step && !stat.scan_grant)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        avail_next = avail_reg;
        count_next = count_reg;
        push = 1'b0;
        push_data.granted_id = pend_reg;
        push_data.status = csw_pkg::STATUS_GRANTED;
        push_data.last = 1'b0;
        if (cmd.rel_start)
        begin
            avail_next = rel_sum[csw_pkg::UNITS_W] ? csw_pkg::UNITS_MAX
                                                   : rel_sum[csw_pkg::UNITS_W-1:0];
        end
        if (cmd.acq_grant)
        begin
            avail_next = avail_reg - acq_need;
            push = 1'b1;
            push_data.granted_id = req_reg.requester_id;
            push_data.last = 1'b1;
        end
        if (cmd.acq_drop)
        begin
            push = 1'b1;
            push_data.granted_id = req_reg.requester_id;
            push_data.status = csw_pkg::STATUS_DROPPED;
            push_data.last = 1'b1;
        end
        if (cmd.acq_queue)
        begin
            count_next = count_reg + csw_pkg::CNT_W'(1);
        end
        if (cmd.scan_step && stat.scan_grant)
        begin
            avail_next = avail_reg - rd_waiter.need;
            push = 1'b1;
        end
        if (cmd.finish)
        begin
            push = 1'b1;
            push_data.last = 1'b1;
            count_next = kept_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            avail_reg <= avail_next;
            count_reg <= count_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (push)
        begin
            out_reg <= push_data;
        end
        if (cmd.rel_start)
        begin
            pend_reg <= req_reg.requester_id;
            idx_reg <= '0;
            kept_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_inc;
            if (stat.scan_grant)
            begin
                pend_reg <= rd_waiter.id;
            end
            else
            begin
                kept_reg <= kept_reg + csw_pkg::CNT_W'(1);
            end
        end
    end

    assign rsp = out_reg;
    assign rsp_valid = out_valid_reg;

endmodule
`default_nettype wire
